[hw/rtl/yuvrgb_pkg.sv]
// Shared constants, types and arithmetic helpers for the YUV420SP to RGB converter.
// No dependencies; used by every module of the converter except yuvrgb_ram.

package yuvrgb_pkg;

  // Line store sizing
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);

  // Field and counter widths
  localparam int SIZE_W   = 13;
  localparam int COL_W    = 11;
  localparam int ROW_W    = 12;
  localparam int PIX_W    = 8;
  localparam int CHROMA_W = 2 * PIX_W;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 3;

  // Q16 colour arithmetic
  localparam int Q_FRAC      = 16;
  localparam int PROD_W      = 26;
  localparam int TERM_W      = 10;
  localparam int SUM_W       = 11;
  localparam int CHROMA_BIAS = 128;
  localparam int PIX_MAX     = 255;

  localparam logic signed [PROD_W-1:0] K_C0_CH0 = PROD_W'(116130);
  localparam logic signed [PROD_W-1:0] K_C0_CH1 = PROD_W'(22544);
  localparam logic signed [PROD_W-1:0] K_C1_CH1 = PROD_W'(46793);
  localparam logic signed [PROD_W-1:0] K_C1_CH2 = PROD_W'(91881);
  localparam logic signed [PROD_W-1:0] TRUNC_BIAS = PROD_W'((1 << Q_FRAC) - 1);

  // Register reset values
  localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(480);

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  // Position of the item being accepted
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              odd;
    logic              eor;
    logic              eof;
  } pos_t;

  // First pipeline stage payload
  typedef struct packed {
    logic [PIX_W-1:0]    luma_left;
    logic [PIX_W-1:0]    luma_right;
    logic [CHROMA_W-1:0] chroma;
    logic                odd;
    logic                eor;
    logic                eof;
  } s1_t;

  // Remove the 128 offset from a chroma byte
  function automatic logic signed [PIX_W:0] chroma_centre(input logic [PIX_W-1:0] b);
    return $signed({1'b0, b}) - $signed((PIX_W + 1)'(CHROMA_BIAS));
  endfunction

  // Divide by 2^16, truncating toward zero
  function automatic logic signed [TERM_W-1:0] trunc_q16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] biased;
    biased = p[PROD_W-1] ? (p + TRUNC_BIAS) : p;
    return TERM_W'(biased >>> Q_FRAC);
  endfunction

  // Add or subtract a colour term to luma and saturate to 0..255
  function automatic logic [PIX_W-1:0] pix_channel(input logic [PIX_W-1:0] y,
                                                   input logic signed [TERM_W-1:0] t,
                                                   input logic sub);
    logic signed [SUM_W-1:0] yw;
    logic signed [SUM_W-1:0] tw;
    logic signed [SUM_W-1:0] s;
    yw = $signed(SUM_W'(y));
    tw = SUM_W'(t);
    s  = sub ? (yw - tw) : (yw + tw);
    if (s < 0) begin
      return '0;
    end else if (s > $signed(SUM_W'(PIX_MAX))) begin
      return PIX_W'(PIX_MAX);
    end else begin
      return s[PIX_W-1:0];
    end
  endfunction

endpackage

[hw/rtl/yuvrgb_ram.sv]
// Generic single-port synchronous RAM with registered read data.
// No dependencies.

module yuvrgb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[hw/rtl/yuvrgb_pos.sv]
// Raster position tracking: pair column and row counters, size limits, end flags.
// Depends on yuvrgb_pkg.

module yuvrgb_pos (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [yuvrgb_pkg::SIZE_W-1:0]  image_width,
  input  logic [yuvrgb_pkg::SIZE_W-1:0]  image_height,
  input  logic                           advance,
  output yuvrgb_pkg::pos_t               pos
);

  logic [yuvrgb_pkg::COL_W-1:0]  pair_column;
  logic [yuvrgb_pkg::COL_W-1:0]  pair_column_next;
  logic [yuvrgb_pkg::ROW_W-1:0]  row_index;
  logic [yuvrgb_pkg::ROW_W-1:0]  row_index_next;
  logic [yuvrgb_pkg::SIZE_W-1:0] width_even;
  logic [yuvrgb_pkg::SIZE_W-1:0] width_lim;
  logic [yuvrgb_pkg::SIZE_W-1:0] height_lim;
  logic [yuvrgb_pkg::SIZE_W-1:0] pairs;
  logic                          eor;
  logic                          eof;

  always_comb begin
    // ignore the low width bit, then limit both sizes
    width_even = {image_width[yuvrgb_pkg::SIZE_W-1:1], 1'b0};
    if (width_even < yuvrgb_pkg::SIZE_W'(2)) begin
      width_lim = yuvrgb_pkg::SIZE_W'(2);
    end else if (int'(width_even) > yuvrgb_pkg::MAX_WIDTH) begin
      width_lim = yuvrgb_pkg::SIZE_W'(yuvrgb_pkg::MAX_WIDTH);
    end else begin
      width_lim = width_even;
    end
    pairs = width_lim >> 1;

    if (image_height < yuvrgb_pkg::SIZE_W'(2)) begin
      height_lim = yuvrgb_pkg::SIZE_W'(2);
    end else if (int'(image_height) > yuvrgb_pkg::MAX_HEIGHT) begin
      height_lim = yuvrgb_pkg::SIZE_W'(yuvrgb_pkg::MAX_HEIGHT);
    end else begin
      height_lim = image_height;
    end

    eor = (yuvrgb_pkg::SIZE_W'(pair_column) + yuvrgb_pkg::SIZE_W'(1)) >= pairs;
    eof = eor && ((yuvrgb_pkg::SIZE_W'(row_index) + yuvrgb_pkg::SIZE_W'(1)) >= height_lim);

    if (eor) begin
      pair_column_next = '0;
      row_index_next   = eof ? '0 : row_index + yuvrgb_pkg::ROW_W'(1);
    end else begin
      pair_column_next = pair_column + yuvrgb_pkg::COL_W'(1);
      row_index_next   = row_index;
    end

    pos.addr = yuvrgb_pkg::ADDR_W'(pair_column);
    pos.odd  = row_index[0];
    pos.eor  = eor;
    pos.eof  = eof;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_column <= '0;
      row_index   <= '0;
    end else if (advance) begin
      pair_column <= pair_column_next;
      row_index   <= row_index_next;
    end
  end

endmodule

[hw/rtl/yuvrgb_color.sv]
// Colour conversion back end: Q16 products, then truncation, luma add and clamp.
// Holds the second stage and the output register; depends on yuvrgb_pkg.

module yuvrgb_color (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s1_valid,
  input  yuvrgb_pkg::s1_t                   s1,
  input  logic [yuvrgb_pkg::CHROMA_W-1:0]   line_q,
  output logic                              ready,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [yuvrgb_pkg::PIX_W-1:0]      left_ch0,
  output logic [yuvrgb_pkg::PIX_W-1:0]      left_ch1,
  output logic [yuvrgb_pkg::PIX_W-1:0]      left_ch2,
  output logic [yuvrgb_pkg::PIX_W-1:0]      right_ch0,
  output logic [yuvrgb_pkg::PIX_W-1:0]      right_ch1,
  output logic [yuvrgb_pkg::PIX_W-1:0]      right_ch2,
  output logic                              end_of_row,
  output logic                              end_of_frame
);

  typedef struct packed {
    logic [yuvrgb_pkg::PIX_W-1:0]         luma_left;
    logic [yuvrgb_pkg::PIX_W-1:0]         luma_right;
    logic signed [yuvrgb_pkg::PROD_W-1:0] p0;
    logic signed [yuvrgb_pkg::PROD_W-1:0] p1;
    logic signed [yuvrgb_pkg::PROD_W-1:0] p2;
    logic                                 eor;
    logic                                 eof;
  } s2_t;

  logic                                 v2;
  s2_t                                  s2;
  s2_t                                  s2_next;
  logic                                 en2;
  logic                                 en3;
  logic [yuvrgb_pkg::CHROMA_W-1:0]      chroma;
  logic signed [yuvrgb_pkg::PIX_W:0]    c0;
  logic signed [yuvrgb_pkg::PIX_W:0]    c1;
  logic signed [yuvrgb_pkg::PROD_W-1:0] c0w;
  logic signed [yuvrgb_pkg::PROD_W-1:0] c1w;
  logic signed [yuvrgb_pkg::TERM_W-1:0] t0;
  logic signed [yuvrgb_pkg::TERM_W-1:0] t1;
  logic signed [yuvrgb_pkg::TERM_W-1:0] t2;

  assign en3   = !out_valid || !out_stall;
  assign en2   = !v2 || en3;
  assign ready = en2;

  // odd rows take the stored chroma pair, even rows their own
  always_comb begin
    chroma = s1.odd ? line_q : s1.chroma;
    c0     = yuvrgb_pkg::chroma_centre(chroma[yuvrgb_pkg::PIX_W-1:0]);
    c1     = yuvrgb_pkg::chroma_centre(chroma[yuvrgb_pkg::CHROMA_W-1:yuvrgb_pkg::PIX_W]);
    c0w    = yuvrgb_pkg::PROD_W'(c0);
    c1w    = yuvrgb_pkg::PROD_W'(c1);

    s2_next.luma_left  = s1.luma_left;
    s2_next.luma_right = s1.luma_right;
    s2_next.p0         = c0w * yuvrgb_pkg::K_C0_CH0;
    s2_next.p1         = c0w * yuvrgb_pkg::K_C0_CH1 + c1w * yuvrgb_pkg::K_C1_CH1;
    s2_next.p2         = c1w * yuvrgb_pkg::K_C1_CH2;
    s2_next.eor        = s1.eor;
    s2_next.eof        = s1.eof;
  end

  always_comb begin
    t0 = yuvrgb_pkg::trunc_q16(s2.p0);
    t1 = yuvrgb_pkg::trunc_q16(s2.p1);
    t2 = yuvrgb_pkg::trunc_q16(s2.p2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en2) begin
        v2 <= s1_valid;
      end
      if (en3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2 <= s2_next;
    end
    if (en3) begin
      left_ch0     <= yuvrgb_pkg::pix_channel(s2.luma_left,  t0, 1'b0);
      left_ch1     <= yuvrgb_pkg::pix_channel(s2.luma_left,  t1, 1'b1);
      left_ch2     <= yuvrgb_pkg::pix_channel(s2.luma_left,  t2, 1'b0);
      right_ch0    <= yuvrgb_pkg::pix_channel(s2.luma_right, t0, 1'b0);
      right_ch1    <= yuvrgb_pkg::pix_channel(s2.luma_right, t1, 1'b1);
      right_ch2    <= yuvrgb_pkg::pix_channel(s2.luma_right, t2, 1'b0);
      end_of_row   <= s2.eor;
      end_of_frame <= s2.eof;
    end
  end

endmodule

[hw/rtl/yuv420sp_to_rgb_converter_core.sv]
// YUV420 semi-planar to RGB888 converter, one pixel pair per item.
// An accepted item passes the first and second stages into the output register.
// Throughput: one item per cycle unless stalled; one line store access per item.
// Reset: counters to the frame start, sizes to 640 x 480; the chroma line store is not
// cleared and holds stale data until an even row writes it (no clearing pass).
// Depends on yuvrgb_pkg, yuvrgb_ram, yuvrgb_pos and yuvrgb_color.

module yuv420sp_to_rgb_converter_core (
  input  logic                              clk,
  input  logic                              rst,

  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [yuvrgb_pkg::PADDR_W-1:0]    paddr,
  input  logic [yuvrgb_pkg::DATA_W-1:0]     pwdata,
  output logic [yuvrgb_pkg::DATA_W-1:0]     prdata,
  output logic                              pready,

  // input items
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [yuvrgb_pkg::PIX_W-1:0]      luma_left,
  input  logic [yuvrgb_pkg::PIX_W-1:0]      luma_right,
  input  logic [yuvrgb_pkg::PIX_W-1:0]      chroma_first,
  input  logic [yuvrgb_pkg::PIX_W-1:0]      chroma_second,

  // result items
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [yuvrgb_pkg::PIX_W-1:0]      left_ch0,
  output logic [yuvrgb_pkg::PIX_W-1:0]      left_ch1,
  output logic [yuvrgb_pkg::PIX_W-1:0]      left_ch2,
  output logic [yuvrgb_pkg::PIX_W-1:0]      right_ch0,
  output logic [yuvrgb_pkg::PIX_W-1:0]      right_ch1,
  output logic [yuvrgb_pkg::PIX_W-1:0]      right_ch2,
  output logic                              end_of_row,
  output logic                              end_of_frame
);

  logic [yuvrgb_pkg::SIZE_W-1:0]   image_width;
  logic [yuvrgb_pkg::SIZE_W-1:0]   image_height;
  yuvrgb_pkg::reg_idx_t            reg_idx;
  logic                            cfg_write;

  yuvrgb_pkg::pos_t                pos;
  logic                            en1;
  logic                            accept;
  logic                            s1_valid;
  yuvrgb_pkg::s1_t                 s1;
  yuvrgb_pkg::s1_t                 s1_next;
  logic [yuvrgb_pkg::CHROMA_W-1:0] chroma_in;
  logic [yuvrgb_pkg::CHROMA_W-1:0] line_q;
  logic                            color_ready;

  // ---------------------------------------------------------------------------
  // Configuration registers. Word address selects the register; the byte
  // offset bits are ignored.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_idx   = yuvrgb_pkg::reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      yuvrgb_pkg::REG_IMAGE_WIDTH:  prdata = yuvrgb_pkg::DATA_W'(image_width);
      yuvrgb_pkg::REG_IMAGE_HEIGHT: prdata = yuvrgb_pkg::DATA_W'(image_height);
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= yuvrgb_pkg::RESET_WIDTH;
      image_height <= yuvrgb_pkg::RESET_HEIGHT;
    end else if (cfg_write) begin
      unique case (reg_idx)
        yuvrgb_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[yuvrgb_pkg::SIZE_W-1:0];
        yuvrgb_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[yuvrgb_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow. Each stage advances when it is empty or the stage after
  // it advances, so bubbles collapse and an item is taken even while a
  // finished result sits on the output register.
  // ---------------------------------------------------------------------------
  assign en1      = !s1_valid || color_ready;
  assign in_stall = !en1;
  assign accept   = in_valid && en1;

  // Raster position of the item at the input
  yuvrgb_pos u_pos (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .advance      (accept),
    .pos          (pos)
  );

  // ---------------------------------------------------------------------------
  // Chroma line store. Even rows write their pair at the pair column, odd
  // rows read the same column back. One access per item, so a write and a
  // read never share a cycle; a read one item after a write to the same
  // entry (two-pixel-wide frames) sees the new data because the write has
  // already landed at the earlier edge. No forwarding path is needed.
  // Read data holds while the first stage holds, since the port only
  // fires on acceptance.
  // ---------------------------------------------------------------------------
  assign chroma_in = {chroma_second, chroma_first};

  yuvrgb_ram #(
    .WIDTH (yuvrgb_pkg::CHROMA_W),
    .DEPTH (yuvrgb_pkg::LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .en    (accept),
    .we    (!pos.odd),
    .addr  (pos.addr),
    .wdata (chroma_in),
    .rdata (line_q)
  );

  // ---------------------------------------------------------------------------
  // First stage: capture luma, own chroma and flags alongside the line
  // store read.
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_next.luma_left  = luma_left;
    s1_next.luma_right = luma_right;
    s1_next.chroma     = chroma_in;
    s1_next.odd        = pos.odd;
    s1_next.eor        = pos.eor;
    s1_next.eof        = pos.eof;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Products, then truncate, add luma and clamp into the output register.
  // ---------------------------------------------------------------------------
  yuvrgb_color u_color (
    .clk          (clk),
    .rst          (rst),
    .s1_valid     (s1_valid),
    .s1           (s1),
    .line_q       (line_q),
    .ready        (color_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .left_ch0     (left_ch0),
    .left_ch1     (left_ch1),
    .left_ch2     (left_ch2),
    .right_ch0    (right_ch0),
    .right_ch1    (right_ch1),
    .right_ch2    (right_ch2),
    .end_of_row   (end_of_row),
    .end_of_frame (end_of_frame)
  );

endmodule
